// ===== design/utf8d_pkg.sv =====
// ----------------------------------------------------------------------------
// utf8d_pkg
// Shared types and constants for the UTF-8 stream decoder.
// ----------------------------------------------------------------------------
package utf8d_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned CP_W   = 21;

    localparam logic [CP_W-1:0]   REPLACEMENT_CP = 21'h00FFFD;

    localparam logic [BYTE_W-1:0] CONT_MASK  = 8'hC0;
    localparam logic [BYTE_W-1:0] CONT_TAG   = 8'h80;
    localparam logic [BYTE_W-1:0] LEAD2_MASK = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD2_TAG  = 8'hC0;
    localparam logic [BYTE_W-1:0] LEAD3_MASK = 8'hF0;
    localparam logic [BYTE_W-1:0] LEAD3_TAG  = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD4_MASK = 8'hF8;
    localparam logic [BYTE_W-1:0] LEAD4_TAG  = 8'hF0;
    localparam logic [BYTE_W-1:0] LEAD2_BITS = 8'h1F;
    localparam logic [BYTE_W-1:0] LEAD3_BITS = 8'h0F;
    localparam logic [BYTE_W-1:0] LEAD4_BITS = 8'h07;
    localparam logic [BYTE_W-1:0] CONT_BITS  = 8'h3F;

    // Results caused by one byte: a run of replacement characters,
    // optionally followed by one final code point.
    typedef struct packed {
        logic [1:0]      repl_cnt;
        logic            has_final;
        logic [CP_W-1:0] final_cp;
        logic            final_eos;
    } burst_t;

endpackage

// ===== design/utf8d_ifs.sv =====
// ----------------------------------------------------------------------------
// utf8d interfaces
// Valid/ready channels for the byte input and the code point output.
// ----------------------------------------------------------------------------
interface utf8d_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;

    modport source (output valid, output text_byte, input ready);
    modport sink   (input valid, input text_byte, output ready);
endinterface

interface utf8d_cp_if;
    logic        valid;
    logic        ready;
    logic [20:0] code_point;
    logic        end_of_string;
    logic        last;

    modport source (output valid, output code_point, output end_of_string,
                    output last, input ready);
    modport sink   (input valid, input code_point, input end_of_string,
                    input last, output ready);
endinterface

// ===== design/utf8d_decode.sv =====
// ----------------------------------------------------------------------------
// utf8d_decode
// Sequence state and per-byte decode into a burst of results.
// ----------------------------------------------------------------------------
module utf8d_decode
    import utf8d_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              take,
    input  logic [BYTE_W-1:0] text_byte,
    output burst_t            burst
);

    logic [1:0]      expected_reg, expected_next;
    logic [1:0]      taken_reg, taken_next;
    logic [CP_W-1:0] partial_reg, partial_next;

    logic            is_cont;
    logic [CP_W-1:0] shifted;

    assign is_cont = (text_byte & CONT_MASK) == CONT_TAG;
    assign shifted = {partial_reg[CP_W-7:0], text_byte[5:0]};

    always_comb
    begin
        expected_next   = expected_reg;
        taken_next      = taken_reg;
        partial_next    = partial_reg;
        burst.repl_cnt  = 2'd0;
        burst.has_final = 1'b0;
        burst.final_cp  = REPLACEMENT_CP;
        burst.final_eos = 1'b0;

        if (expected_reg != 2'd0 && is_cont)
        begin
            expected_next = expected_reg - 2'd1;
            taken_next    = taken_reg + 2'd1;
            partial_next  = shifted;
            if (expected_reg == 2'd1)
            begin
                burst.has_final = 1'b1;
                burst.final_cp  = shifted;
                taken_next      = 2'd0;
                partial_next    = '0;
            end
        end
        else
        begin
            if (expected_reg != 2'd0)
            begin
                // broken sequence: one for the lead, one per continuation
                burst.repl_cnt = (taken_reg > 2'd2) ? 2'd3 : taken_reg + 2'd1;
                expected_next  = 2'd0;
                taken_next     = 2'd0;
                partial_next   = '0;
            end

            if (text_byte == '0)
            begin
                burst.has_final = 1'b1;
                burst.final_cp  = '0;
                burst.final_eos = 1'b1;
            end
            else if (!text_byte[7])
            begin
                burst.has_final = 1'b1;
                burst.final_cp  = {{(CP_W-BYTE_W){1'b0}}, text_byte};
            end
            else if ((text_byte & LEAD2_MASK) == LEAD2_TAG)
            begin
                partial_next  = {{(CP_W-BYTE_W){1'b0}}, text_byte & LEAD2_BITS};
                expected_next = 2'd1;
            end
            else if ((text_byte & LEAD3_MASK) == LEAD3_TAG)
            begin
                partial_next  = {{(CP_W-BYTE_W){1'b0}}, text_byte & LEAD3_BITS};
                expected_next = 2'd2;
            end
            else if ((text_byte & LEAD4_MASK) == LEAD4_TAG)
            begin
                partial_next  = {{(CP_W-BYTE_W){1'b0}}, text_byte & LEAD4_BITS};
                expected_next = 2'd3;
            end
            else
            begin
                // stray continuation or F8..FF
                burst.has_final = 1'b1;
                burst.final_cp  = REPLACEMENT_CP;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_reg <= 2'd0;
            taken_reg    <= 2'd0;
            partial_reg  <= '0;
        end
        else if (take)
        begin
            expected_reg <= expected_next;
            taken_reg    <= taken_next;
            partial_reg  <= partial_next;
        end
    end

`ifndef SYNTHESIS
    a_idle_no_taken: assert property (@(posedge clk) disable iff (!rst_n)
        expected_reg == 2'd0 |-> taken_reg == 2'd0)
        else $error("continuations counted with no open sequence");

    a_seq_length: assert property (@(posedge clk) disable iff (!rst_n)
        expected_reg != 2'd0 |-> ({1'b0, expected_reg} + {1'b0, taken_reg}) <= 3'd3)
        else $error("open sequence longer than four bytes");

    a_break_clears: assert property (@(posedge clk) disable iff (!rst_n)
        take && expected_reg != 2'd0 && !is_cont |=> taken_reg == 2'd0)
        else $error("broken sequence left continuation count");
`endif

endmodule

// ===== design/utf8d_emit.sv =====
// ----------------------------------------------------------------------------
// utf8d_emit
// Result register: plays out one burst, one result per cycle while the receiver is ready.
// ----------------------------------------------------------------------------
module utf8d_emit
    import utf8d_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        load,
    input  burst_t      burst_in,
    output logic        free,
    utf8d_cp_if.source  result
);

    logic [1:0]      repl_reg, repl_next;
    logic            final_reg, final_next;
    logic [CP_W-1:0] cp_reg, cp_next;
    logic            eos_reg, eos_next;

    logic empty;
    logic out_last;
    logic fire;

    assign empty    = (repl_reg == 2'd0) && !final_reg;
    assign out_last = (repl_reg == 2'd0) || (repl_reg == 2'd1 && !final_reg);
    assign fire     = result.valid && result.ready;
    assign free     = empty || (fire && out_last);

    assign result.valid         = !empty;
    assign result.code_point    = (repl_reg != 2'd0) ? REPLACEMENT_CP : cp_reg;
    assign result.end_of_string = (repl_reg == 2'd0) && eos_reg;
    assign result.last          = out_last;

    always_comb
    begin
        repl_next  = repl_reg;
        final_next = final_reg;
        cp_next    = cp_reg;
        eos_next   = eos_reg;
        if (load)
        begin
            repl_next  = burst_in.repl_cnt;
            final_next = burst_in.has_final;
            cp_next    = burst_in.final_cp;
            eos_next   = burst_in.final_eos;
        end
        else if (fire)
        begin
            if (repl_reg != 2'd0)
                repl_next = repl_reg - 2'd1;
            else
                final_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            repl_reg  <= 2'd0;
            final_reg <= 1'b0;
        end
        else
        begin
            repl_reg  <= repl_next;
            final_reg <= final_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cp_reg  <= cp_next;
        eos_reg <= eos_next;
    end

`ifndef SYNTHESIS
    a_burst_continues: assert property (@(posedge clk) disable iff (!rst_n)
        fire && !out_last |=> result.valid)
        else $error("burst dropped before its last result");

    a_burst_ends: assert property (@(posedge clk) disable iff (!rst_n)
        fire && out_last && !load |=> !result.valid)
        else $error("result shown after burst ended");

    a_repl_first: assert property (@(posedge clk) disable iff (!rst_n)
        load && burst_in.repl_cnt != 2'd0 |=>
            result.code_point == REPLACEMENT_CP && !result.end_of_string)
        else $error("replacement run not shown first");
`endif

endmodule

// ===== design/utf8_stream_decoder.sv =====
// ----------------------------------------------------------------------------
// utf8_stream_decoder
// Byte-serial UTF-8 decoder with valid/ready channels.
// ----------------------------------------------------------------------------
//  channel   dir   payload                              per transaction
//  text      in    text_byte[7:0]                       one raw byte
//  result    out   code_point[20:0], end_of_string,     one code point
//                  last
//
//  One byte is taken per cycle while the result register is free; a byte
//  causing several results holds the input until they are all accepted, so
//  a broken sequence causes up to four results. A new byte is taken in the
//  cycle its predecessor's last result is accepted.
//  Reset clears the sequence state and empties the result register.
//  A stalled output holds its result and blocks new bytes until the last
//  result of the pending burst is accepted.
// ----------------------------------------------------------------------------
module utf8_stream_decoder
    import utf8d_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    utf8d_byte_if.sink  text,
    utf8d_cp_if.source  result
);

    burst_t burst;
    logic   free;
    logic   take;

    assign text.ready = free;
    assign take       = text.valid && free;

    utf8d_decode u_decode (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .text_byte (text.text_byte),
        .burst     (burst)
    );

    utf8d_emit u_emit (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (take),
        .burst_in (burst),
        .free     (free),
        .result   (result)
    );

endmodule

// ===== test/utf8_stream_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// utf8_stream_checker
// Watches both channels of the UTF-8 stream decoder. It decodes every
// accepted byte into the code points it should cause, and compares each
// accepted result transaction with the oldest one still outstanding.
// ----------------------------------------------------------------------------
module utf8_stream_checker
    import utf8d_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    utf8d_byte_if  text,
    utf8d_cp_if    result,
    output int     fail_count,
    output int     pending
);

    typedef struct packed {
        logic [CP_W-1:0] code_point;
        logic            end_of_string;
        logic            last;
    } cp_result_t;

    cp_result_t      expected_cps[$];
    logic [1:0]      conts_needed;
    logic [1:0]      conts_taken;
    logic [CP_W-1:0] partial_cp;

    task automatic push_cp(input logic [CP_W-1:0] cp, input logic eos);
        cp_result_t r;
        r.code_point    = cp;
        r.end_of_string = eos;
        r.last          = 1'b0;
        expected_cps.push_back(r);
    endtask

    task automatic decode_byte(input logic [BYTE_W-1:0] b);
        int   base;
        int   k;
        logic absorbed;
        base     = expected_cps.size();
        absorbed = 1'b0;
        if (conts_needed != 2'd0) begin
            if ((b & CONT_MASK) == CONT_TAG) begin
                partial_cp   = {partial_cp[CP_W-7:0], b[5:0]};
                conts_needed = conts_needed - 2'd1;
                conts_taken  = conts_taken + 2'd1;
                if (conts_needed == 2'd0) begin
                    push_cp(partial_cp, 1'b0);
                    conts_taken = 2'd0;
                    partial_cp  = '0;
                end
                absorbed = 1'b1;
            end else begin
                // broken sequence: one replacement for the lead, one per
                // continuation already taken, then the byte starts over
                push_cp(REPLACEMENT_CP, 1'b0);
                for (k = 0; k < conts_taken && k < 2; k++)
                    push_cp(REPLACEMENT_CP, 1'b0);
                conts_needed = 2'd0;
                conts_taken  = 2'd0;
                partial_cp   = '0;
            end
        end
        if (!absorbed) begin
            if (b == 8'h00) begin
                push_cp('0, 1'b1);
            end else if (b < CONT_TAG) begin
                push_cp(CP_W'(b), 1'b0);
            end else if ((b & LEAD2_MASK) == LEAD2_TAG) begin
                partial_cp   = CP_W'(b & LEAD2_BITS);
                conts_needed = 2'd1;
            end else if ((b & LEAD3_MASK) == LEAD3_TAG) begin
                partial_cp   = CP_W'(b & LEAD3_BITS);
                conts_needed = 2'd2;
            end else if ((b & LEAD4_MASK) == LEAD4_TAG) begin
                partial_cp   = CP_W'(b & LEAD4_BITS);
                conts_needed = 2'd3;
            end else begin
                push_cp(REPLACEMENT_CP, 1'b0);
            end
        end
        if (expected_cps.size() > base)
            expected_cps[expected_cps.size()-1].last = 1'b1;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        cp_result_t want;
        if (!rst_n) begin
            expected_cps.delete();
            conts_needed = 2'd0;
            conts_taken  = 2'd0;
            partial_cp   = '0;
            fail_count   = 0;
            pending      = 0;
        end else begin
            // predict first so a result of this very byte would still line up
            if (text.valid && text.ready)
                decode_byte(text.text_byte);
            if (result.valid && result.ready) begin
                if (expected_cps.size() == 0) begin
                    fail_count++;
                    $display("%0t: result with none outstanding: expected none, actual cp=%h eos=%b last=%b",
                             $time, result.code_point, result.end_of_string, result.last);
                end else begin
                    want = expected_cps.pop_front();
                    if (result.code_point !== want.code_point) begin
                        fail_count++;
                        $display("%0t: code_point expected %h actual %h",
                                 $time, want.code_point, result.code_point);
                    end
                    if (result.end_of_string !== want.end_of_string) begin
                        fail_count++;
                        $display("%0t: end_of_string expected %b actual %b",
                                 $time, want.end_of_string, result.end_of_string);
                    end
                    if (result.last !== want.last) begin
                        fail_count++;
                        $display("%0t: last expected %b actual %b",
                                 $time, want.last, result.last);
                    end
                end
            end
            pending = expected_cps.size();
        end
    end

endmodule

// ===== test/utf8_stream_decoder_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// utf8_stream_decoder_test
// Drives a byte stream into the UTF-8 stream decoder: a directed run over
// ASCII, stray and invalid bytes, every sequence length and broken sequences,
// then random text made mostly of well-formed sequences. Both channels idle
// at random; the receiver holds off once for a long stretch and the sender
// pauses once until the decoder has drained.
// ----------------------------------------------------------------------------
module utf8_stream_decoder_test;
    import utf8d_pkg::*;

    localparam int IDLE_PCT     = 34;
    localparam int HOLD_CYCLES  = 80;
    localparam int RANDOM_BYTES = 250;
    localparam int DRAIN_LIMIT  = 20000;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending;
    int   bytes_sent;
    bit   quiet;
    bit   hold_req;

    utf8d_byte_if text();
    utf8d_cp_if   result();

    logic [7:0] directed_bytes [25] = '{
        8'h41, 8'h7F, 8'h80, 8'hFF, 8'hF8, 8'h00,
        8'hC0, 8'h80,                          // overlong, decoded as is
        8'hE2, 8'h82, 8'hAC,
        8'hF7, 8'hBF, 8'hBF, 8'hBF,            // all 21 bits set
        8'hC3, 8'h41,
        8'hF0, 8'h90, 8'h80, 8'hC3, 8'hA9,     // broken after two, new lead
        8'hE2, 8'h82, 8'h00                    // zero inside a sequence
    };

    utf8_stream_decoder dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .text   (text),
        .result (result)
    );

    utf8_stream_checker stream_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .text       (text),
        .result     (result),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #200000;
        $display("FAIL utf8_stream_decoder");
        $finish;
    end

    // receiver: random stalls, plus one long hold-off on request
    initial
    begin
        int hold_left;
        hold_left    = 0;
        result.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                result.ready <= 1'b0;
                hold_left--;
            end else if (quiet) begin
                result.ready <= 1'b1;
            end else begin
                result.ready <= ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    // called at a falling edge, returns at the falling edge after the transaction
    task automatic send_byte(input logic [7:0] b);
        while (!quiet && $urandom_range(99) < IDLE_PCT) begin
            text.valid <= 1'b0;
            @(negedge clk);
        end
        text.valid     <= 1'b1;
        text.text_byte <= b;
        do @(posedge clk); while (!text.ready);
        bytes_sent++;
        @(negedge clk);
    endtask

    function automatic logic [7:0] lead_byte(input int len);
        logic [7:0] r;
        r = 8'($urandom);
        case (len)
            2:       return LEAD2_TAG | (r & LEAD2_BITS);
            3:       return LEAD3_TAG | (r & LEAD3_BITS);
            default: return LEAD4_TAG | (r & LEAD4_BITS);
        endcase
    endfunction

    function automatic logic [7:0] cont_byte();
        return CONT_TAG | (8'($urandom) & CONT_BITS);
    endfunction

    task automatic send_text_unit();
        int         kind;
        int         len;
        int         k;
        logic [7:0] b;
        kind = $urandom_range(99);
        len  = $urandom_range(1, 4);
        if (kind < 60) begin
            if (len == 1) begin
                send_byte(8'($urandom_range(1, 127)));
            end else begin
                send_byte(lead_byte(len));
                for (k = 1; k < len; k++)
                    send_byte(cont_byte());
            end
        end else if (kind < 75) begin
            // sequence cut short by any non-continuation byte
            if (len == 1)
                len = 2;
            send_byte(lead_byte(len));
            for (k = $urandom_range(0, len - 2); k > 0; k--)
                send_byte(cont_byte());
            b = 8'($urandom);
            if ((b & CONT_MASK) == CONT_TAG)
                b[6] = 1'b1;
            send_byte(b);
        end else if (kind < 80) begin
            send_byte(8'h00);
        end else begin
            send_byte(8'($urandom_range(0, 255)));
        end
    endtask

    initial
    begin
        int waited;
        bit held;
        bit paused;
        waited         = 0;
        held           = 1'b0;
        paused         = 1'b0;
        bytes_sent     = 0;
        quiet          = 1'b0;
        hold_req       = 1'b0;
        rst_n          = 1'b0;
        text.valid     = 1'b0;
        text.text_byte = 8'h00;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (directed_bytes[i])
            send_byte(directed_bytes[i]);

        while (bytes_sent < RANDOM_BYTES + $size(directed_bytes)) begin
            quiet = (bytes_sent >= 120 && bytes_sent < 170);
            if (!held && bytes_sent >= 60) begin
                held     = 1'b1;
                hold_req = 1'b1;
            end
            if (!paused && bytes_sent >= 210) begin
                paused     = 1'b1;
                text.valid <= 1'b0;
                @(negedge clk);
                while (pending != 0)
                    @(negedge clk);
            end
            send_text_unit();
        end
        quiet      = 1'b0;
        text.valid <= 1'b0;

        while (pending != 0 && waited < DRAIN_LIMIT) begin
            @(negedge clk);
            waited++;
        end
        repeat (8) @(posedge clk);
        if (pending != 0)
            $display("%0t: results outstanding: expected 0 actual %0d", $time, pending);
        if (fail_count == 0 && pending == 0)
            $display("PASS utf8_stream_decoder");
        else
            $display("FAIL utf8_stream_decoder");
        $finish;
    end

endmodule
